// ----- hdl/hrt_pkg.sv -----
// Shared types, constants and key helpers for the hashed record table.
`timescale 1ns / 1ps

package hrt_pkg;

    // Default sizing of the table and of the stored record word.
    localparam int HRT_TABLE_SLOTS  = 100;
    localparam int HRT_PAYLOAD_BITS = 64;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_MODIFY = 2'd3;

    // Key geometry.
    localparam logic [3:0] KEY_MAX_LEN   = 4'd11;
    localparam int         KEY_PAD_BYTES = 12;
    localparam logic [7:0] PAD_BYTE      = 8'h20;
    localparam int         KEY_WORD_BITS = 4 + 64 + 24;

    // Hash arithmetic: T = 100 * (sum of even bytes) + (sum of odd bytes).
    localparam int PAIR_SCALE  = 100;
    localparam int HASH_MOD    = 20000;
    localparam int SLOT_MOD    = 99;
    localparam int T_MAX       = (KEY_PAD_BYTES / 2) * (PAIR_SCALE * 255 + 255);
    localparam int MOD_STEPS   = T_MAX / HASH_MOD;
    localparam int BSUM_BITS   = 11;
    localparam int T_BITS      = 18;
    localparam int M_BITS      = 15;
    localparam int Q_BITS      = 8;
    localparam int PROD_BITS   = 29;
    localparam int RECIP       = 21183;
    localparam int RECIP_SHIFT = 21;

    // One request item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key_head;
        logic [23:0] key_tail;
        logic [3:0]  key_len;
        logic [63:0] new_key_head;
        logic [23:0] new_key_tail;
        logic [3:0]  new_key_len;
        logic [63:0] payload;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic        ok;
        logic [6:0]  slot;
        logic [63:0] record;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic hash_sel;
        logic load_s;
        logic load_ns;
        logic rd_en;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_modify;
        logic res_free;
    } dp_status_t;

    // Lengths above eleven count as eleven.
    function automatic logic [3:0] clamp_len(input logic [3:0] len);
        return (len > KEY_MAX_LEN) ? KEY_MAX_LEN : len;
    endfunction

    // Zero the head bytes at or beyond the key length.
    function automatic logic [63:0] mask_head(input logic [63:0] head, input logic [3:0] len);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                r[63 - 8 * i -: 8] = head[63 - 8 * i -: 8];
            end
        end
        return r;
    endfunction

    // Zero the tail bytes at or beyond the key length.
    function automatic logic [23:0] mask_tail(input logic [23:0] tail, input logic [3:0] len);
        logic [23:0] r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            if (4'(i + 8) < len) begin
                r[23 - 8 * i -: 8] = tail[23 - 8 * i -: 8];
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/hrt_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module hrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds when not enabled.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/hrt_ctrl.sv -----
// Sequencing state machine for the hashed record table.
`timescale 1ns / 1ps

module hrt_ctrl
    import hrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_S_SUM = 11'b000_0000_0010,
        ST_S_MOD = 11'b000_0000_0100,
        ST_S_QUO = 11'b000_0000_1000,
        ST_S_SLT = 11'b000_0001_0000,
        ST_N_SUM = 11'b000_0010_0000,
        ST_N_MOD = 11'b000_0100_0000,
        ST_N_QUO = 11'b000_1000_0000,
        ST_N_SLT = 11'b001_0000_0000,
        ST_READ  = 11'b010_0000_0000,
        ST_CHECK = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Only the idle state takes a new item.
    assign req_stall = (state_reg != ST_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = ST_S_SUM;
                end
            end
            ST_S_SUM: state_next = ST_S_MOD;
            ST_S_MOD: state_next = ST_S_QUO;
            ST_S_QUO: state_next = ST_S_SLT;
            ST_S_SLT:
            begin
                cmd.load_s = 1'b1;
                state_next = status.is_modify ? ST_N_SUM : ST_READ;
            end
            ST_N_SUM:
            begin
                cmd.hash_sel = 1'b1;
                cmd.rd_en    = 1'b1;
                state_next   = ST_N_MOD;
            end
            ST_N_MOD:
            begin
                cmd.hash_sel = 1'b1;
                state_next   = ST_N_QUO;
            end
            ST_N_QUO:
            begin
                cmd.hash_sel = 1'b1;
                state_next   = ST_N_SLT;
            end
            ST_N_SLT:
            begin
                cmd.hash_sel = 1'b1;
                cmd.load_ns  = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // Table update and result load happen together once the
                // result register can take a new item.
                cmd.commit = status.res_free;
                if (status.res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/hrt_dp.sv -----
// Datapath: key capture, staged hash, slot stores and result register.
`timescale 1ns / 1ps

module hrt_dp
    import hrt_pkg::*;
#(
    parameter int TABLE_SLOTS  = HRT_TABLE_SLOTS,
    parameter int PAYLOAD_BITS = HRT_PAYLOAD_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  in_item_t   req,
    input  logic       rsp_stall,
    output logic       rsp_valid,
    output out_item_t  rsp
);

    localparam int SLOT_AW = $clog2(TABLE_SLOTS);

    // Captured item, keys already trimmed to their lengths.
    logic [1:0]              kind_reg;
    logic [63:0]             k_head_reg;
    logic [23:0]             k_tail_reg;
    logic [3:0]              k_len_reg;
    logic [63:0]             nk_head_reg;
    logic [23:0]             nk_tail_reg;
    logic [3:0]              nk_len_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    // Hash pipeline.
    logic [T_BITS-1:0]       t_reg;
    logic [T_BITS-1:0]       t_next;
    logic [M_BITS-1:0]       m_reg;
    logic [M_BITS-1:0]       m_next;
    logic [Q_BITS-1:0]       q_reg;
    logic [M_BITS-1:0]       mq_reg;
    logic [PROD_BITS-1:0]    prod;
    logic [M_BITS-1:0]       qm;
    logic [Q_BITS-1:0]       r1;
    logic [6:0]              slot_val;
    logic [6:0]              s_reg;
    logic [6:0]              ns_reg;

    // Store signals.
    logic                    valid_reg [TABLE_SLOTS];
    logic [SLOT_AW-1:0]      s_addr;
    logic [SLOT_AW-1:0]      ns_addr;
    logic [KEY_WORD_BITS-1:0] rd_key;
    logic [PAYLOAD_BITS-1:0] rd_rec;
    logic                    holds;
    logic                    op_ok;
    logic                    wr_en;
    logic                    clr_en;
    logic [SLOT_AW-1:0]      wr_addr;
    logic [KEY_WORD_BITS-1:0] wr_key;

    // Result register.
    logic                    rsp_valid_reg;
    out_item_t               rsp_reg;

    assign s_addr  = SLOT_AW'(s_reg);
    assign ns_addr = SLOT_AW'(ns_reg);

    // Item capture with key trimming.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= req.kind;
            k_len_reg   <= clamp_len(req.key_len);
            k_head_reg  <= mask_head(req.key_head, clamp_len(req.key_len));
            k_tail_reg  <= mask_tail(req.key_tail, clamp_len(req.key_len));
            nk_len_reg  <= clamp_len(req.new_key_len);
            nk_head_reg <= mask_head(req.new_key_head, clamp_len(req.new_key_len));
            nk_tail_reg <= mask_tail(req.new_key_tail, clamp_len(req.new_key_len));
            pay_reg     <= req.payload[PAYLOAD_BITS-1:0];
        end
    end

    // Hash stage one: space-padded byte sums folded into one total.
    always_comb
    begin
        logic [95:0]          kb;
        logic [3:0]           hl;
        logic [7:0]           b;
        logic [BSUM_BITS-1:0] even_sum;
        logic [BSUM_BITS-1:0] odd_sum;
        kb       = cmd.hash_sel ? {nk_head_reg, nk_tail_reg, PAD_BYTE}
                                : {k_head_reg, k_tail_reg, PAD_BYTE};
        hl       = cmd.hash_sel ? nk_len_reg : k_len_reg;
        even_sum = '0;
        odd_sum  = '0;
        for (int i = 0; i < KEY_PAD_BYTES; i++) begin
            b = (4'(i) < hl) ? kb[95 - 8 * i -: 8] : PAD_BYTE;
            if ((i % 2) == 0) begin
                even_sum = even_sum + BSUM_BITS'(b);
            end
            else begin
                odd_sum = odd_sum + BSUM_BITS'(b);
            end
        end
        t_next = T_BITS'(even_sum) * T_BITS'(PAIR_SCALE) + T_BITS'(odd_sum);
    end

    // Hash stage two: total modulo 20000 by comparison against its multiples.
    always_comb
    begin
        m_next = M_BITS'(t_reg);
        for (int i = 1; i <= MOD_STEPS; i++) begin
            if (t_reg >= T_BITS'(i * HASH_MOD)) begin
                m_next = M_BITS'(t_reg - T_BITS'(i * HASH_MOD));
            end
        end
    end

    // Hash stage three: quotient estimate by reciprocal multiplication.
    assign prod = PROD_BITS'(m_reg) * PROD_BITS'(RECIP);

    // Hash stage four: remainder with one correction step.
    assign qm       = M_BITS'(q_reg) * M_BITS'(SLOT_MOD);
    assign r1       = Q_BITS'(mq_reg - qm);
    assign slot_val = (r1 >= Q_BITS'(SLOT_MOD)) ? 7'(r1 - Q_BITS'(SLOT_MOD)) : 7'(r1);

    // Hash pipeline registers and slot capture.
    always_ff @(posedge clk)
    begin
        t_reg  <= t_next;
        m_reg  <= m_next;
        q_reg  <= Q_BITS'(prod >> RECIP_SHIFT);
        mq_reg <= m_reg;
        if (cmd.load_s)
        begin
            s_reg <= slot_val;
        end
        if (cmd.load_ns)
        begin
            ns_reg <= slot_val;
        end
    end

    // Key and record stores.
    hrt_ram #(
        .WIDTH (KEY_WORD_BITS),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_key),
        .re    (cmd.rd_en),
        .raddr (s_addr),
        .rdata (rd_key)
    );

    hrt_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (TABLE_SLOTS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (pay_reg),
        .re    (cmd.rd_en),
        .raddr (s_addr),
        .rdata (rd_rec)
    );

    // Match of the stored entry against the key.
    assign holds = (k_len_reg != 4'd0) && valid_reg[s_addr] &&
                   (rd_key == {k_len_reg, k_head_reg, k_tail_reg});

    // Operation outcome and table updates.
    always_comb
    begin
        op_ok   = 1'b0;
        wr_en   = 1'b0;
        clr_en  = 1'b0;
        wr_addr = s_addr;
        wr_key  = {k_len_reg, k_head_reg, k_tail_reg};
        unique case (kind_reg)
            KIND_INSERT:
            begin
                op_ok = (k_len_reg != 4'd0) && !holds;
                wr_en = cmd.commit && op_ok;
            end
            KIND_LOOKUP:
            begin
                op_ok = holds;
            end
            KIND_DELETE:
            begin
                op_ok  = holds;
                clr_en = cmd.commit && op_ok;
            end
            KIND_MODIFY:
            begin
                op_ok   = (nk_len_reg != 4'd0) && holds;
                clr_en  = cmd.commit && op_ok;
                wr_en   = cmd.commit && op_ok;
                wr_addr = ns_addr;
                wr_key  = {nk_len_reg, nk_head_reg, nk_tail_reg};
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // Occupancy bits; a set at the new slot follows the clear of the old one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (clr_en)
            begin
                valid_reg[s_addr] <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.ok     <= op_ok;
            rsp_reg.slot   <= (kind_reg == KIND_MODIFY) ? ns_reg : s_reg;
            rsp_reg.record <= (op_ok && (kind_reg == KIND_LOOKUP || kind_reg == KIND_DELETE))
                              ? 64'(rd_rec) : 64'd0;
        end
    end

    assign status.is_modify = (kind_reg == KIND_MODIFY);
    assign status.res_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid        = rsp_valid_reg;
    assign rsp              = rsp_reg;

endmodule

// ----- hdl/hashed_record_table_no_collision_core.sv -----
// Top level of the direct-mapped hashed record table.
//
//   Channel | Direction | Handshake           | Payload
//   req     | input     | req_valid/req_stall | in_item_t  (kind, keys, payload)
//   rsp     | output    | rsp_valid/rsp_stall | out_item_t (ok, slot, record)
//
// An item passes from acceptance to commit through the four-stage slot hash,
// which runs once per key, and the registered read of the key and record
// memories. One item is in work at a time, so a new item is taken only after
// the last one has committed.
// Reset clears every slot's occupancy bit at once; no clearing pass is needed.
// A stalled result holds in the output register while the next item is taken;
// the following commit waits until that register is free.
`timescale 1ns / 1ps

module hashed_record_table_no_collision_core
    import hrt_pkg::*;
#(
    parameter int TABLE_SLOTS  = HRT_TABLE_SLOTS,
    parameter int PAYLOAD_BITS = HRT_PAYLOAD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_item_t  req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_item_t rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer.
    hrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Hash, stores and result register.
    hrt_dp #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ----- hdl/hrt_checker.sv -----
// Port-level checks for the hashed record table, bound to the top level.
`timescale 1ns / 1ps

module hrt_port_checks
    import hrt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input in_item_t  req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input out_item_t rsp
);

    // An accepted item keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while block was not busy afterwards");

    // A stalled result stays valid and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed or dropped");

    // The reported slot is always a hash remainder.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.slot < 7'(SLOT_MOD)))
        else $error("result slot out of hash range");

    // A failed operation returns no record.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> (rsp.record == 64'd0))
        else $error("record returned on failed operation");

    // A fresh result only appears after the block was working on an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared without an item in work");

endmodule

bind hashed_record_table_no_collision_core hrt_port_checks u_hrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ----- verif/hrt_checker.sv -----
// Result checker for the hashed record table: predicts every result and compares it.
`timescale 1ns / 1ps

module hrt_checker
    import hrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  in_item_t  req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  out_item_t rsp,
    output int        outstanding,
    output int        fail_count,
    output int        results_seen,
    output int        ok_seen
);

    localparam int MAX_REPORTS = 200;

    // A key as the table stores it: clamped length, bytes past the length zeroed.
    typedef struct packed {
        logic [63:0] head;
        logic [23:0] tail;
        logic [3:0]  len;
    } table_key_t;

    // Own copy of the table contents.
    table_key_t  slot_key  [HRT_TABLE_SLOTS];
    logic [63:0] slot_data [HRT_TABLE_SLOTS];

    // Results predicted for accepted items, oldest first.
    out_item_t   pending_results[$];

    int errors;
    int seen;
    int hits;

    // Bring a raw key to its stored form.
    function automatic table_key_t trim_key(logic [63:0] head, logic [23:0] tail,
                                            logic [3:0] len);
        table_key_t k;
        logic [3:0] n;
        n = (len > KEY_MAX_LEN) ? KEY_MAX_LEN : len;
        k.len  = n;
        k.head = (n >= 8) ? head : head & ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * n));
        k.tail = (n <= 8) ? 24'h0 : tail & ~(24'hFF_FFFF >> (8 * (n - 8)));
        return k;
    endfunction

    // Byte i of the space-padded 12-byte key.
    function automatic int unsigned key_char(table_key_t k, int i);
        if (i >= k.len) begin
            return 32'(PAD_BYTE);
        end
        if (i < 8) begin
            return 32'(k.head[63 - 8 * i -: 8]);
        end
        return 32'(k.tail[23 - 8 * (i - 8) -: 8]);
    endfunction

    // Fold-and-add hash over the six byte pairs, reduced to a slot.
    function automatic logic [6:0] hash_slot(table_key_t k);
        int unsigned sum;
        sum = 0;
        for (int j = 0; j < KEY_PAD_BYTES; j += 2) begin
            sum = (sum + PAIR_SCALE * key_char(k, j) + key_char(k, j + 1)) % HASH_MOD;
        end
        return 7'(sum % SLOT_MOD);
    endfunction

    // An empty key never matches; otherwise the stored form must be identical.
    function automatic logic slot_matches(logic [6:0] s, table_key_t k);
        return (k.len != 0) && (slot_key[s] == k);
    endfunction

    // Apply one item to the table copy and return the result it should give.
    function automatic out_item_t predict_table_op(in_item_t it);
        table_key_t k;
        table_key_t nk;
        logic [6:0] s;
        logic [6:0] ns;
        out_item_t  r;
        k  = trim_key(it.key_head, it.key_tail, it.key_len);
        nk = trim_key(it.new_key_head, it.new_key_tail, it.new_key_len);
        s  = hash_slot(k);
        r.ok     = 1'b0;
        r.slot   = s;
        r.record = '0;
        case (it.kind)
            KIND_INSERT:
            begin
                if (k.len != 0 && !slot_matches(s, k)) begin
                    slot_key[s]  = k;
                    slot_data[s] = it.payload;
                    r.ok = 1'b1;
                end
            end
            KIND_LOOKUP:
            begin
                if (slot_matches(s, k)) begin
                    r.ok     = 1'b1;
                    r.record = slot_data[s];
                end
            end
            KIND_DELETE:
            begin
                if (slot_matches(s, k)) begin
                    r.ok         = 1'b1;
                    r.record     = slot_data[s];
                    slot_key[s]  = '0;
                    slot_data[s] = '0;
                end
            end
            default:
            begin
                // Modify reports the new key's slot whether or not it succeeds.
                ns = hash_slot(nk);
                r.slot = ns;
                if (nk.len != 0 && slot_matches(s, k)) begin
                    slot_key[s]   = '0;
                    slot_data[s]  = '0;
                    slot_key[ns]  = nk;
                    slot_data[ns] = it.payload;
                    r.ok = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // Print one line per mismatch, up to a cap, and count every one.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("Mismatch at %0t ns: %s is %0h, expected %0h", $time, what, got, want);
        end
    endtask

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge clk or negedge rst_n) begin : track_items
        out_item_t want;
        if (!rst_n) begin
            for (int i = 0; i < HRT_TABLE_SLOTS; i++) begin
                slot_key[i]  = '0;
                slot_data[i] = '0;
            end
            pending_results.delete();
            outstanding <= 0;
        end
        else begin
            if (req_valid && !req_stall) begin
                pending_results.push_back(predict_table_op(req));
            end
            if (rsp_valid && !rsp_stall) begin
                seen++;
                if (rsp.ok) begin
                    hits++;
                end
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, slot", 64'(rsp.slot), 64'd0);
                end
                else begin
                    want = pending_results.pop_front();
                    if (rsp.ok !== want.ok) begin
                        report_mismatch("ok", 64'(rsp.ok), 64'(want.ok));
                    end
                    if (rsp.slot !== want.slot) begin
                        report_mismatch("slot", 64'(rsp.slot), 64'(want.slot));
                    end
                    if (rsp.record !== want.record) begin
                        report_mismatch("record", rsp.record, want.record);
                    end
                end
            end
            outstanding  <= pending_results.size();
            fail_count   <= errors;
            results_seen <= seen;
            ok_seen      <= hits;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the hashed record table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import hrt_pkg::*;

    localparam int GAP_MAX      = 7;
    localparam int STALL_MAX    = 7;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 1125;
    localparam int POOL_SIZE    = 16;

    typedef struct packed {
        logic [63:0] head;
        logic [23:0] tail;
        logic [3:0]  len;
    } text_key_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_item_t  req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_item_t rsp;

    int outstanding;
    int fail_count;
    int results_seen;
    int ok_seen;

    int        sent_by_kind[4];
    int        idle_cycles = 0;
    int        stall_left  = 0;
    int        recv_count  = 0;
    logic      send_quiet  = 1'b0;
    logic      recv_quiet  = 1'b0;
    text_key_t key_pool[POOL_SIZE];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hashed_record_table_no_collision_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    hrt_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .outstanding  (outstanding),
        .fail_count   (fail_count),
        .results_seen (results_seen),
        .ok_seen      (ok_seen)
    );

    // Result side: after each taken result, hold off for a random number of cycles.
    always @(posedge clk or negedge rst_n) begin : result_pacing
        int wait_n;
        if (!rst_n) begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (rsp_valid && !rsp_stall) begin
            wait_n = recv_quiet ? 0 : $urandom_range(0, STALL_MAX);
            rsp_stall  <= (wait_n != 0);
            stall_left <= wait_n;
            recv_count <= recv_count + 1;
            // Now and then run a stretch of results with no stalls at all.
            if (recv_count % 64 == 63) begin
                recv_quiet <= ($urandom_range(0, 3) == 0);
            end
        end
        else if (stall_left > 0) begin
            rsp_stall  <= (stall_left > 1);
            stall_left <= stall_left - 1;
        end
    end

    // Give up when neither channel has moved for too long.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one item after a random gap and hold it until it is taken.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) begin
            @(posedge clk);
        end
        sent_by_kind[it.kind]++;
    endtask

    task automatic send_op(input logic [1:0] kind, input text_key_t k, input text_key_t nk,
                           input logic [63:0] pay);
        in_item_t it;
        it.kind         = kind;
        it.key_head     = k.head;
        it.key_tail     = k.tail;
        it.key_len      = k.len;
        it.new_key_head = nk.head;
        it.new_key_tail = nk.tail;
        it.new_key_len  = nk.len;
        it.payload      = pay;
        send_item(it);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
    endtask

    // Any length from 0 to 15 with fully random bytes.
    function automatic text_key_t random_key();
        text_key_t k;
        k.head = {$urandom, $urandom};
        k.tail = 24'($urandom);
        k.len  = 4'($urandom_range(0, 15));
        return k;
    endfunction

    // Fill the bytes past the length with junk; a full-length key may use an overlong length.
    function automatic text_key_t scramble(input text_key_t k);
        for (int i = 0; i < 8; i++) begin
            if (i >= k.len) begin
                k.head[63 - 8 * i -: 8] = 8'($urandom_range(0, 255));
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (i + 8 >= k.len) begin
                k.tail[23 - 8 * i -: 8] = 8'($urandom_range(0, 255));
            end
        end
        if (k.len == KEY_MAX_LEN && $urandom_range(0, 1) == 1) begin
            k.len = 4'($urandom_range(11, 15));
        end
        return k;
    endfunction

    function automatic text_key_t pool_key();
        return scramble(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
    endfunction

    // New working set of keys; every odd entry swaps the first two byte pairs of its
    // neighbor when it can, which lands on the same slot with a different key.
    task automatic refill_pool();
        text_key_t k;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i % 2 == 1 && key_pool[i - 1].len >= 4) begin
                k = key_pool[i - 1];
                k.head = {k.head[47:32], k.head[63:48], k.head[31:0]};
            end
            else begin
                k = random_key();
                k.len = 4'($urandom_range(1, 11));
            end
            key_pool[i] = k;
        end
    endtask

    // Main stimulus.
    initial begin : stimulus
        text_key_t  ka;
        text_key_t  kb;
        text_key_t  kx;
        text_key_t  kz;
        text_key_t  kz0;
        text_key_t  kfull;
        text_key_t  kfull11;
        text_key_t  kfull10;
        text_key_t  knone;
        text_key_t  k;
        text_key_t  nk;
        logic [1:0] kind;
        int         roll;

        ka      = '{head: 64'h4142_4344_0000_0000, tail: 24'h0, len: 4'd4};
        kb      = '{head: 64'h4344_4142_0000_0000, tail: 24'h0, len: 4'd4};
        kx      = '{head: 64'h5859_5A00_0000_0000, tail: 24'h0, len: 4'd3};
        kz      = '{head: 64'h00FF_FFFF_FFFF_FFFF, tail: 24'hFF_FFFF, len: 4'd1};
        kz0     = '{head: 64'h0, tail: 24'h0, len: 4'd1};
        kfull   = '{head: 64'hFFFF_FFFF_FFFF_FFFF, tail: 24'hFF_FFFF, len: 4'd15};
        kfull11 = '{head: 64'hFFFF_FFFF_FFFF_FFFF, tail: 24'hFF_FFFF, len: 4'd11};
        kfull10 = '{head: 64'hFFFF_FFFF_FFFF_FFFF, tail: 24'hFF_FFFF, len: 4'd10};
        knone   = '{head: 64'hFFFF_FFFF_FFFF_FFFF, tail: 24'hFF_FFFF, len: 4'd0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, empty keys, extreme bytes and lengths, a slot clash,
        // and every outcome of each operation.
        send_op(KIND_LOOKUP, ka, random_key(), 64'h0);
        send_op(KIND_INSERT, knone, random_key(), 64'h1111);
        send_op(KIND_INSERT, kz, random_key(), 64'h0);
        send_op(KIND_INSERT, kz, random_key(), 64'h1);
        send_op(KIND_LOOKUP, kz0, random_key(), 64'h2);
        send_op(KIND_INSERT, kfull, random_key(), 64'hFFFF_FFFF_FFFF_FFFF);
        send_op(KIND_LOOKUP, kfull11, random_key(), 64'h0);
        send_op(KIND_LOOKUP, kfull10, random_key(), 64'h0);
        send_op(KIND_INSERT, ka, random_key(), 64'hA5A5_0000_0000_00AA);
        send_op(KIND_INSERT, kb, random_key(), 64'h0000_5A5A_BBBB_0000);
        send_op(KIND_LOOKUP, ka, random_key(), 64'h0);
        send_op(KIND_LOOKUP, kb, random_key(), 64'h0);
        send_op(KIND_MODIFY, kb, kx, 64'hCCCC_CCCC_CCCC_CCCC);
        send_op(KIND_LOOKUP, kb, random_key(), 64'h0);
        send_op(KIND_LOOKUP, kx, random_key(), 64'h0);
        send_op(KIND_MODIFY, kx, knone, 64'h1234);
        send_op(KIND_MODIFY, ka, kx, 64'h5678);
        send_op(KIND_MODIFY, kx, kx, 64'hDDDD_0000_DDDD_0000);
        send_op(KIND_DELETE, kx, random_key(), 64'h0);
        send_op(KIND_DELETE, kx, random_key(), 64'h0);
        send_op(KIND_LOOKUP, knone, random_key(), 64'h0);
        send_op(KIND_DELETE, knone, random_key(), 64'h0);
        send_op(KIND_MODIFY, knone, ka, 64'h9999);
        send_op(KIND_DELETE, kfull11, random_key(), 64'h0);
        drain_results();

        // Random: mostly operations on a small set of keys so that hits, clashes and
        // refusals are common, with some fully random items mixed in.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 200 == 0) begin
                refill_pool();
            end
            if (i % 50 == 0) begin
                send_quiet = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                roll = $urandom_range(0, 99);
                kind = (roll < 30) ? KIND_INSERT :
                       (roll < 60) ? KIND_LOOKUP :
                       (roll < 75) ? KIND_DELETE : KIND_MODIFY;
                k  = ($urandom_range(0, 9) == 0) ? random_key() : pool_key();
                nk = ($urandom_range(0, 4) == 0) ? random_key() : pool_key();
            end
            else begin
                kind = 2'($urandom_range(0, 3));
                k    = random_key();
                nk   = random_key();
            end
            send_op(kind, k, nk, {$urandom, $urandom});
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d inserts, %0d lookups, %0d deletes, %0d modifies.",
                 sent_by_kind[KIND_INSERT] + sent_by_kind[KIND_LOOKUP] +
                 sent_by_kind[KIND_DELETE] + sent_by_kind[KIND_MODIFY],
                 sent_by_kind[KIND_INSERT], sent_by_kind[KIND_LOOKUP],
                 sent_by_kind[KIND_DELETE], sent_by_kind[KIND_MODIFY]);
        $display("Compared %0d results, %0d of them reporting success.",
                 results_seen, ok_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end
        else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/hrt_pkg.sv
hdl/hrt_ram.sv
hdl/hrt_ctrl.sv
hdl/hrt_dp.sv
hdl/hashed_record_table_no_collision_core.sv
hdl/hrt_checker.sv
verif/hrt_checker.sv
verif/tb_top.sv
